// ===== sv/rpwu_pkg.sv =====
// ----------------------------------------------------------------------------
// rpwu_pkg: shared types and constants for the Rprop weight update block
// Transaction payloads, per-weight row layout, register map and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwu_pkg;

    // Number of weights held in the per-weight store (at most 2**IDX_W).
    localparam int WEIGHT_COUNT = 1024;
    localparam int WADDR_W      = $clog2(WEIGHT_COUNT);
    // Fraction bits of the Q formats; the zero band lives at twice this scale.
    localparam int FRAC_BITS    = 16;
    // Fraction bits of the grow/shrink factors (Q2.14).
    localparam int FACTOR_BITS  = 14;

    localparam int IDX_W        = 10;
    localparam int DATA_W       = 32;
    localparam int FACTOR_W     = 16;
    localparam int GSH_W        = DATA_W + FRAC_BITS;
    localparam int SCALED_W     = DATA_W + FACTOR_W;
    localparam int SHIFTED_W    = SCALED_W - FACTOR_BITS;

    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Register index within the configuration map (byte address = 4 * index).
    typedef enum logic [2:0] {
        REG_GROW_FACTOR   = 3'd0,
        REG_SHRINK_FACTOR = 3'd1,
        REG_STEP_CEILING  = 3'd2,
        REG_STEP_FLOOR    = 3'd3,
        REG_STEP_INITIAL  = 3'd4,
        REG_ZERO_BAND     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic        [IDX_W-1:0]  weight_index;
        logic signed [DATA_W-1:0] gradient;
        logic signed [DATA_W-1:0] weight_in;
        logic        [DATA_W-1:0] epoch_error;
        logic                     last_of_pass;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] weight_out;
        logic signed [DATA_W-1:0] weight_delta;
    } result_t;

    // One row of the per-weight store.
    typedef struct packed {
        logic                     seen;
        logic signed [DATA_W-1:0] kept_gradient;
        logic signed [DATA_W-1:0] last_change;
        logic        [DATA_W-1:0] step_size;
    } row_t;

endpackage : rpwu_pkg

`default_nettype wire

// ===== sv/rprop_weight_update.sv =====
// ----------------------------------------------------------------------------
// rprop_weight_update: resilient backpropagation weight update pipeline
// Streams per-weight transactions, updates step size, kept gradient and last
// change in an on-chip row store, and returns the change and new weight.
// ----------------------------------------------------------------------------
// The block takes one weight transaction per clock when item_stall is low
// and returns one result per transaction, in order. A transaction passes an
// accept stage that issues the row-store read, four compute stages (product,
// classify and scale, step and change select, weight add and write-back) and
// an output register, which drives result_valid. The row store has one
// write and one read port; a transaction whose weight_index matches one
// still in the four compute stages is held off with item_stall until that
// one has written back, while distinct indices stream at one per clock
// unless item_stall or result_stall holds them. After reset the store is
// swept clear, one row a clock over all WEIGHT_COUNT (1024) rows, with
// item_stall high; configuration writes are taken throughout. The error
// compare uses prior_error as left by all earlier transactions, and a
// transaction with last_of_pass set latches its epoch_error at acceptance.
`default_nettype none

module rprop_weight_update
    import rpwu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // input transactions
    input  wire logic                  item_valid,
    output      logic                  item_stall,
    input  wire item_t                 item,

    // result transactions
    output      logic                  result_valid,
    input  wire logic                  result_stall,
    output      result_t               result,

    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output      logic [CFG_DATA_W-1:0] prdata,
    output      logic                  pready
);

    // ------------------------------------------------------------------
    // Stage payloads
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        [WADDR_W-1:0] idx;
        logic                      in_range;
        logic signed [DATA_W-1:0]  gradient;
        logic signed [DATA_W-1:0]  weight_in;
        logic                      err_rose;
    } s1_t;

    typedef struct packed {
        logic        [WADDR_W-1:0] idx;
        logic                      in_range;
        logic signed [DATA_W-1:0]  gradient;
        logic signed [DATA_W-1:0]  weight_in;
        logic                      err_rose;
        logic signed [2*DATA_W-1:0] prod;
        logic        [DATA_W-1:0]  step_prev;
        logic signed [DATA_W-1:0]  last_change;
        logic                      g_nz;    // gradient outside the zero band
        logic                      g_pos;   // gradient strictly positive
    } s2_t;

    typedef struct packed {
        logic        [WADDR_W-1:0] idx;
        logic                      in_range;
        logic signed [DATA_W-1:0]  gradient;
        logic signed [DATA_W-1:0]  weight_in;
        logic                      err_rose;
        logic        [DATA_W-1:0]  step_prev;
        logic signed [DATA_W-1:0]  last_change;
        logic                      g_nz;
        logic                      g_pos;
        logic                      cls_pos;
        logic                      cls_neg;
        logic        [SCALED_W-1:0] grown;
        logic        [SCALED_W-1:0] shrunk;
    } s3_t;

    typedef struct packed {
        logic        [WADDR_W-1:0] idx;
        logic                      in_range;
        logic signed [DATA_W-1:0]  weight_in;
        logic        [DATA_W-1:0]  step_new;
        logic signed [DATA_W-1:0]  kept_new;
        logic signed [DATA_W-1:0]  change;
    } s4_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FACTOR_W-1:0] grow_factor_reg;
    logic [FACTOR_W-1:0] shrink_factor_reg;
    logic [DATA_W-1:0]   step_ceiling_reg;
    logic [DATA_W-1:0]   step_floor_reg;
    logic [DATA_W-1:0]   step_initial_reg;
    logic [DATA_W-1:0]   zero_band_reg;

    logic     cfg_we;
    cfg_reg_t cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_factor_reg   <= FACTOR_W'(19661);
            shrink_factor_reg <= FACTOR_W'(8192);
            step_ceiling_reg  <= DATA_W'(3276800);
            step_floor_reg    <= DATA_W'(1);
            step_initial_reg  <= DATA_W'(6554);
            zero_band_reg     <= DATA_W'(4295);
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_GROW_FACTOR:   grow_factor_reg   <= pwdata[FACTOR_W-1:0];
                REG_SHRINK_FACTOR: shrink_factor_reg <= pwdata[FACTOR_W-1:0];
                REG_STEP_CEILING:  step_ceiling_reg  <= pwdata[DATA_W-1:0];
                REG_STEP_FLOOR:    step_floor_reg    <= pwdata[DATA_W-1:0];
                REG_STEP_INITIAL:  step_initial_reg  <= pwdata[DATA_W-1:0];
                REG_ZERO_BAND:     zero_band_reg     <= pwdata[DATA_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_GROW_FACTOR:   prdata = CFG_DATA_W'(grow_factor_reg);
            REG_SHRINK_FACTOR: prdata = CFG_DATA_W'(shrink_factor_reg);
            REG_STEP_CEILING:  prdata = CFG_DATA_W'(step_ceiling_reg);
            REG_STEP_FLOOR:    prdata = CFG_DATA_W'(step_floor_reg);
            REG_STEP_INITIAL:  prdata = CFG_DATA_W'(step_initial_reg);
            REG_ZERO_BAND:     prdata = CFG_DATA_W'(zero_band_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage moves when the one after it is free
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic result_valid_reg;
    s1_t  s1_reg;
    s2_t  s2_reg;
    s3_t  s3_reg;
    s4_t  s4_reg;

    logic adv_out, adv4, adv3, adv2, adv1;
    logic hazard;
    logic accept;
    logic clearing_reg;
    logic [WADDR_W-1:0] clear_addr_reg;
    logic [WADDR_W-1:0] item_addr;

    assign adv_out = !result_valid_reg || !result_stall;
    assign adv4    = !s4_valid_reg || adv_out;
    assign adv3    = !s3_valid_reg || adv4;
    assign adv2    = !s2_valid_reg || adv3;
    assign adv1    = !s1_valid_reg || adv2;

    assign item_addr = item.weight_index[WADDR_W-1:0];

    // Same index still in flight: its write-back has not reached the store.
    assign hazard = (s1_valid_reg && s1_reg.idx == item_addr)
                 || (s2_valid_reg && s2_reg.idx == item_addr)
                 || (s3_valid_reg && s3_reg.idx == item_addr)
                 || (s4_valid_reg && s4_reg.idx == item_addr);

    assign item_stall = !adv1 || hazard || clearing_reg;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= accept;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (adv_out)
            begin
                result_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Error latch: compare against the error left by earlier transactions
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] prior_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_error_reg <= '0;
        end
        else if (accept && item.last_of_pass)
        begin
            prior_error_reg <= item.epoch_error;
        end
    end

    // ------------------------------------------------------------------
    // Row store: one write port, one registered read port
    // ------------------------------------------------------------------
    row_t               row_mem [WEIGHT_COUNT];
    row_t               rdata_reg;
    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    row_t               mem_wdata;
    row_t               wb_row;

    assign wb_row.seen          = 1'b1;
    assign wb_row.kept_gradient = s4_reg.kept_new;
    assign wb_row.last_change   = s4_reg.change;
    assign wb_row.step_size     = s4_reg.step_new;

    assign mem_we    = clearing_reg || (s4_valid_reg && adv_out && s4_reg.in_range);
    assign mem_waddr = clearing_reg ? clear_addr_reg : s4_reg.idx;
    assign mem_wdata = clearing_reg ? row_t'('0) : wb_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= row_mem[item_addr];
        end
    end

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == WADDR_W'(WEIGHT_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept: capture the transaction
    // ------------------------------------------------------------------
    s1_t s1_next;

    assign s1_next.idx       = item_addr;
    assign s1_next.in_range  = (32'(item.weight_index) < 32'(WEIGHT_COUNT));
    assign s1_next.gradient  = item.gradient;
    assign s1_next.weight_in = item.weight_in;
    assign s1_next.err_rose  = item.epoch_error > prior_error_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // S1: gradient product, previous step, gradient zero test
    // ------------------------------------------------------------------
    s2_t               s2_next;
    logic [DATA_W-1:0] s1_g_mag;
    logic [GSH_W-1:0]  s1_g_shift;

    assign s1_g_mag   = s1_reg.gradient[DATA_W-1] ? DATA_W'(-s1_reg.gradient)
                                                  : DATA_W'(s1_reg.gradient);
    assign s1_g_shift = {s1_g_mag, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        s2_next.idx         = s1_reg.idx;
        s2_next.in_range    = s1_reg.in_range;
        s2_next.gradient    = s1_reg.gradient;
        s2_next.weight_in   = s1_reg.weight_in;
        s2_next.err_rose    = s1_reg.err_rose;
        s2_next.prod        = s1_reg.gradient * rdata_reg.kept_gradient;
        s2_next.step_prev   = rdata_reg.seen ? rdata_reg.step_size : step_initial_reg;
        s2_next.last_change = rdata_reg.last_change;
        s2_next.g_nz        = !(s1_g_shift < GSH_W'(zero_band_reg));
        s2_next.g_pos       = !s1_reg.gradient[DATA_W-1] && (s1_reg.gradient != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // S2: classify the product; scale the step both ways
    // ------------------------------------------------------------------
    s3_t                 s3_next;
    logic [2*DATA_W-1:0] s2_mag;
    logic                s2_zero;
    logic                s2_pos;

    assign s2_mag  = s2_reg.prod[2*DATA_W-1] ? (2*DATA_W)'(-s2_reg.prod)
                                             : (2*DATA_W)'(s2_reg.prod);
    assign s2_zero = s2_mag < (2*DATA_W)'(zero_band_reg);
    // a zero product outside a zero-width band counts as a sign flip
    assign s2_pos  = !s2_reg.prod[2*DATA_W-1] && (s2_reg.prod != '0);

    always_comb
    begin
        s3_next.idx         = s2_reg.idx;
        s3_next.in_range    = s2_reg.in_range;
        s3_next.gradient    = s2_reg.gradient;
        s3_next.weight_in   = s2_reg.weight_in;
        s3_next.err_rose    = s2_reg.err_rose;
        s3_next.step_prev   = s2_reg.step_prev;
        s3_next.last_change = s2_reg.last_change;
        s3_next.g_nz        = s2_reg.g_nz;
        s3_next.g_pos       = s2_reg.g_pos;
        s3_next.cls_pos     = !s2_zero && s2_pos;
        s3_next.cls_neg     = !s2_zero && !s2_pos;
        s3_next.grown       = SCALED_W'(s2_reg.step_prev) * SCALED_W'(grow_factor_reg);
        s3_next.shrunk      = SCALED_W'(s2_reg.step_prev) * SCALED_W'(shrink_factor_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    // ------------------------------------------------------------------
    // S3: clamp the step, pick the change and the kept gradient
    // ------------------------------------------------------------------
    s4_t                      s4_next;
    logic [SHIFTED_W-1:0]     s3_grow_sh;
    logic [SHIFTED_W-1:0]     s3_shrink_sh;
    logic [DATA_W-1:0]        s3_capped;
    logic [DATA_W-1:0]        s3_floored;
    logic [DATA_W-1:0]        s3_step_next;
    logic signed [DATA_W-1:0] s3_revert;
    logic signed [DATA_W-1:0] s3_move;
    logic signed [DATA_W-1:0] s3_change_next;

    assign s3_grow_sh   = s3_reg.grown[SCALED_W-1:FACTOR_BITS];
    assign s3_shrink_sh = s3_reg.shrunk[SCALED_W-1:FACTOR_BITS];
    assign s3_capped    = (s3_grow_sh > SHIFTED_W'(step_ceiling_reg))
                        ? step_ceiling_reg : s3_grow_sh[DATA_W-1:0];
    // floor is checked on the full value, then the step keeps its low word
    assign s3_floored   = (s3_shrink_sh < SHIFTED_W'(step_floor_reg))
                        ? step_floor_reg : s3_shrink_sh[DATA_W-1:0];

    always_comb
    begin
        if (s3_reg.cls_pos)
        begin
            s3_step_next = s3_capped;
        end
        else if (s3_reg.cls_neg)
        begin
            s3_step_next = s3_floored;
        end
        else
        begin
            s3_step_next = s3_reg.step_prev;
        end
    end

    // negating the most negative change saturates
    assign s3_revert = (s3_reg.last_change == S32_MIN) ? S32_MAX : -s3_reg.last_change;

    always_comb
    begin
        if (!s3_reg.g_nz)
        begin
            s3_move = '0;
        end
        else if (s3_reg.g_pos)
        begin
            s3_move = s3_step_next[DATA_W-1] ? S32_MAX : $signed(s3_step_next);
        end
        else
        begin
            s3_move = s3_step_next[DATA_W-1] ? S32_MIN : -$signed(s3_step_next);
        end
    end

    always_comb
    begin
        if (!s3_reg.in_range)
        begin
            s3_change_next = '0;
        end
        else if (s3_reg.cls_neg)
        begin
            s3_change_next = s3_reg.err_rose ? s3_revert : '0;
        end
        else
        begin
            s3_change_next = s3_move;
        end
    end

    always_comb
    begin
        s4_next.idx       = s3_reg.idx;
        s4_next.in_range  = s3_reg.in_range;
        s4_next.weight_in = s3_reg.weight_in;
        s4_next.step_new  = s3_step_next;
        s4_next.kept_new  = s3_reg.cls_neg ? '0 : s3_reg.gradient;
        s4_next.change    = s3_change_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // S4: saturating weight add; row write-back on the way out
    // ------------------------------------------------------------------
    logic signed [DATA_W:0]   s4_sum;
    logic signed [DATA_W-1:0] s4_weight_next;
    result_t                  result_reg;
    result_t                  result_next;

    assign s4_sum = (DATA_W+1)'(s4_reg.weight_in) + (DATA_W+1)'(s4_reg.change);

    always_comb
    begin
        if (s4_sum[DATA_W] != s4_sum[DATA_W-1])
        begin
            s4_weight_next = s4_sum[DATA_W] ? S32_MIN : S32_MAX;
        end
        else
        begin
            s4_weight_next = s4_sum[DATA_W-1:0];
        end
    end

    assign result_next.weight_out   = s4_weight_next;
    assign result_next.weight_delta = s4_reg.change;

    always_ff @(posedge clk)
    begin
        if (adv_out && s4_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the interlock keeps one transaction per index in flight
    a_no_dup_s1_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |-> (s1_reg.idx != s2_reg.idx))
        else $error("same index in S1 and S2");

    a_no_dup_s1_s4: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s4_valid_reg) |-> (s1_reg.idx != s4_reg.idx))
        else $error("same index in S1 and S4");

    // write-back never competes with the clearing sweep
    a_wb_not_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && adv_out) |-> !clearing_reg)
        else $error("write-back during clearing sweep");

    // the sweep ends only after the last row
    a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clear_addr_reg) == WADDR_W'(WEIGHT_COUNT - 1)))
        else $error("clearing sweep ended early");

endmodule : rprop_weight_update

`default_nettype wire

// ===== tb/tb_rprop_weight_update.sv =====
// ----------------------------------------------------------------------------
// tb_rprop_weight_update: self-checking bench for the Rprop weight update block
// Walks a directed stimulus table and then randomized phases under several
// register settings. Each accepted transaction is scored against its typed
// result or a local Rprop predictor with per-weight step, gradient, change stores.
// ----------------------------------------------------------------------------
module tb_rprop_weight_update
    import rpwu_pkg::*;
();

    localparam int RANDOM_ITEMS  = 850;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 5;
    localparam int DRAIN_CYCLES  = 8;     // four compute stages plus output reg
    localparam int IDLE_LIMIT    = 4000;  // covers the store sweep after reset
    localparam int HOT_COUNT     = 16;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum {CLS_NEG, CLS_ZERO, CLS_POS} grad_class_t;
    typedef enum {SET_DEFAULT, SET_TYPICAL, SET_LOW, SET_HIGH} setting_t;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        row_kind_t         kind;
        cfg_reg_t          reg_id;
        logic [31:0]       value;
        item_t             it;
        bit                known;
        result_t           res;
    } stim_row_t;

    typedef struct {
        bit                known;
        result_t           res;
    } typed_result_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rprop_weight_update u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register shadows and per-weight stores
    // ------------------------------------------------------------------------
    logic [15:0]        grow_q        = 16'd19661;
    logic [15:0]        shrink_q      = 16'd8192;
    logic [31:0]        step_ceil_q   = 32'd3276800;
    logic [31:0]        step_floor_q  = 32'd1;
    logic [31:0]        step_init_q   = 32'd6554;
    logic [31:0]        zero_band_q   = 32'd4295;

    logic [31:0]        step_mem   [WEIGHT_COUNT];
    bit                 seen_mem   [WEIGHT_COUNT];
    logic signed [31:0] kept_mem   [WEIGHT_COUNT];
    logic signed [31:0] change_mem [WEIGHT_COUNT];
    logic [31:0]        prior_err  = '0;

    result_t            due_results[$];   // predicted results, oldest first
    typed_result_t      typed_results[$]; // per driven transaction, in order
    stim_row_t          directed_rows[$];

    int                 errors        = 0;
    int                 items_taken   = 0;
    int                 results_seen  = 0;
    int                 reg_writes    = 0;
    int                 settings_run  = 0;
    int                 idle_cycles   = 0;
    int                 burst_left    = 1;

    // Random stimulus helpers: a small set of hot weights gets most traffic so
    // that sign agreement, flips and reverts are reached; last_grad tracks the
    // gradient most recently sent for each weight.
    logic [IDX_W-1:0]   hot_idx    [HOT_COUNT];
    logic signed [31:0] last_grad  [WEIGHT_COUNT];

    // ------------------------------------------------------------------------
    // Rprop predictor
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(S32_MAX))
            return S32_MAX;
        if (v < longint'(S32_MIN))
            return S32_MIN;
        return v[31:0];
    endfunction

    // -1, 0 or +1; the gradient is scaled up to the product's fraction bits
    // before the zero-band test.
    function automatic int grad_dir(logic signed [31:0] g);
        longint      gl;
        logic [63:0] mag;
        gl  = g;
        mag = (gl < 0) ? -gl : gl;
        if ((mag << FRAC_BITS) < {32'b0, zero_band_q})
            return 0;
        return (gl > 0) ? 1 : -1;
    endfunction

    function automatic longint signed_step(int dir, logic [31:0] step);
        if (dir > 0)
            return clamp32(longint'(step));
        if (dir < 0)
            return clamp32(-longint'(step));
        return 0;
    endfunction

    function automatic result_t rprop_predict(item_t it);
        int unsigned  i;
        logic [31:0]  step;
        longint       g;
        longint       w;
        longint       prod;
        longint       change;
        logic [63:0]  mag;
        logic [63:0]  scaled;
        grad_class_t  cls;
        result_t      r;

        i      = it.weight_index;
        g      = $signed(it.gradient);
        w      = $signed(it.weight_in);
        change = 0;
        step   = seen_mem[i] ? step_mem[i] : step_init_q;
        prod   = g * longint'(kept_mem[i]);
        mag    = (prod < 0) ? -prod : prod;

        if (mag < {32'b0, zero_band_q})
            cls = CLS_ZERO;
        else if (prod > 0)
            cls = CLS_POS;
        else
            cls = CLS_NEG;

        case (cls)
            CLS_POS:
            begin
                scaled = ({32'b0, step} * {48'b0, grow_q}) >> FACTOR_BITS;
                if (scaled > {32'b0, step_ceil_q})
                    scaled = {32'b0, step_ceil_q};
                step        = scaled[31:0];
                change      = signed_step(grad_dir(it.gradient), step);
                kept_mem[i] = it.gradient;
            end
            CLS_NEG:
            begin
                scaled = ({32'b0, step} * {48'b0, shrink_q}) >> FACTOR_BITS;
                if (scaled < {32'b0, step_floor_q})
                    scaled = {32'b0, step_floor_q};
                step = scaled[31:0];
                // sign flip with a rising error undoes the last move
                if (it.epoch_error > prior_err)
                    change = clamp32(-longint'(change_mem[i]));
                kept_mem[i] = '0;
            end
            default:
            begin
                change      = signed_step(grad_dir(it.gradient), step);
                kept_mem[i] = it.gradient;
            end
        endcase

        step_mem[i]   = step;
        seen_mem[i]   = 1'b1;
        change_mem[i] = change[31:0];

        r.weight_delta = change[31:0];
        r.weight_out   = clamp32(w + change);
        if (it.last_of_pass)
            prior_err = it.epoch_error;
        return r;
    endfunction

    function automatic void shadow_write(cfg_reg_t r, logic [31:0] v);
        case (r)
            REG_GROW_FACTOR:   grow_q       = v[15:0];
            REG_SHRINK_FACTOR: shrink_q     = v[15:0];
            REG_STEP_CEILING:  step_ceil_q  = v;
            REG_STEP_FLOOR:    step_floor_q = v;
            REG_STEP_INITIAL:  step_init_q  = v;
            REG_ZERO_BAND:     zero_band_q  = v;
            default:           ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard and watchdog: inputs and outputs are sampled at the rising
    // edge, before any update scheduled for that edge lands.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        bit            progress;
        result_t       want;
        typed_result_t note;
        result_t       pred;

        if (rst_n)
        begin
            progress = 1'b0;
            if (item_valid && !item_stall)
            begin
                pred = rprop_predict(item);
                note = typed_results.pop_front();
                due_results.push_back(note.known ? note.res : pred);
                items_taken++;
                progress = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                progress = 1'b1;
                results_seen++;
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, expected none, actual out=%h delta=%h",
                             $time, result.weight_out, result.weight_delta);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.weight_out !== want.weight_out)
                    begin
                        errors++;
                        $display("%0t: weight_out mismatch, expected %h, actual %h",
                                 $time, want.weight_out, result.weight_out);
                    end
                    if (result.weight_delta !== want.weight_delta)
                    begin
                        errors++;
                        $display("%0t: weight_delta mismatch, expected %h, actual %h",
                                 $time, want.weight_delta, result.weight_delta);
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, due_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side backpressure: modes change at random intervals, including
    // stretches with no stall at all.
    // ------------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 64;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(32, 200);
        end
        else
            stall_left <= stall_left - 1;

        case (stall_mode)
            STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: result_stall <= ((stall_left % 5) < 2);
            default:        result_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each is entered right after a rising edge
    // ------------------------------------------------------------------------

    // Present one transaction and hold it until accepted. Valid stays high on
    // return so a back-to-back transaction needs no second assignment.
    task automatic send_item(input item_t it, input bit known, input result_t res);
        typed_result_t note;
        note.known = known;
        note.res   = res;
        typed_results.push_back(note);
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic pause_sender(input int cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Burst bookkeeping: random-length bursts, random gaps between them.
    task automatic after_item();
        burst_left--;
        if (burst_left <= 0)
        begin
            pause_sender($urandom_range(1, 7));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Registers change only with nothing in flight.
    task automatic wait_idle();
        pause_sender(1);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        logic [31:0] mask;
        mask    = (r == REG_GROW_FACTOR || r == REG_SHRINK_FACTOR) ? 32'h0000_FFFF
                                                                     : 32'hFFFF_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v & mask;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_write(r, v & mask);
        reg_writes++;

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (v & mask))
        begin
            errors++;
            $display("%0t: register %s read-back mismatch, expected %h, actual %h",
                     $time, r.name(), v & mask, prdata & mask);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input setting_t s);
        settings_run++;
        case (s)
            SET_DEFAULT:
            begin
                write_reg(REG_GROW_FACTOR,   32'd19661);
                write_reg(REG_SHRINK_FACTOR, 32'd8192);
                write_reg(REG_STEP_CEILING,  32'd3276800);
                write_reg(REG_STEP_FLOOR,    32'd1);
                write_reg(REG_STEP_INITIAL,  32'd6554);
                write_reg(REG_ZERO_BAND,     32'd4295);
            end
            SET_LOW:
            begin
                write_reg(REG_GROW_FACTOR,   32'd0);
                write_reg(REG_SHRINK_FACTOR, 32'd0);
                write_reg(REG_STEP_CEILING,  32'd0);
                write_reg(REG_STEP_FLOOR,    32'd0);
                write_reg(REG_STEP_INITIAL,  32'd0);
                write_reg(REG_ZERO_BAND,     32'd0);
            end
            SET_HIGH:
            begin
                write_reg(REG_GROW_FACTOR,   32'h0000_FFFF);
                write_reg(REG_SHRINK_FACTOR, 32'h0000_FFFF);
                write_reg(REG_STEP_CEILING,  32'hFFFF_FFFF);
                write_reg(REG_STEP_FLOOR,    32'hFFFF_FFFF);
                write_reg(REG_STEP_INITIAL,  32'hFFFF_FFFF);
                write_reg(REG_ZERO_BAND,     32'hFFFF_FFFF);
            end
            default:
            begin
                // plausible training values: grow at or above one, shrink below
                write_reg(REG_GROW_FACTOR,   $urandom_range(16384, 32767));
                write_reg(REG_SHRINK_FACTOR, $urandom_range(4096, 16383));
                write_reg(REG_STEP_CEILING,  $urandom_range(32'h1_0000, 32'h7FFF_FFFF));
                write_reg(REG_STEP_FLOOR,    $urandom_range(0, 1000));
                write_reg(REG_STEP_INITIAL,  $urandom_range(1, 32'h4_0000));
                write_reg(REG_ZERO_BAND,     $urandom_range(0, 32'h1000_0000));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic item_t random_item();
        item_t              it;
        int unsigned        pick;
        logic signed [31:0] mag;
        logic signed [31:0] prev;
        int                 flip;

        it.weight_index = ($urandom_range(0, 9) < 7) ? hot_idx[$urandom_range(0, HOT_COUNT-1)]
                                                     : IDX_W'($urandom_range(0, WEIGHT_COUNT-1));
        prev = last_grad[it.weight_index];
        mag  = $urandom_range(1, 32'h3_FFFF);
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            // mostly keep the sign (step grows), sometimes flip it (shrink)
            flip = (pick < 40) ? 0 : 1;
            if (prev == 0)
                it.gradient = $urandom_range(0, 1) ? mag : -mag;
            else if ((prev > 0) ^ flip)
                it.gradient = mag;
            else
                it.gradient = -mag;
        end
        else if (pick < 80)
            it.gradient = int'($urandom_range(0, 6)) - 3;   // around the zero band
        else if (pick < 90)
            it.gradient = $urandom();
        else
            case ($urandom_range(0, 4))
                0:       it.gradient = S32_MAX;
                1:       it.gradient = S32_MIN;
                2:       it.gradient = 32'sd1;
                3:       it.gradient = -32'sd1;
                default: it.gradient = '0;
            endcase
        last_grad[it.weight_index] = it.gradient;

        pick = $urandom_range(0, 9);
        if (pick < 8)
            it.weight_in = int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
        else if (pick < 9)
            it.weight_in = $urandom_range(0, 1) ? S32_MAX - $urandom_range(0, 32'h1_0000)
                                                : S32_MIN + $urandom_range(0, 32'h1_0000);
        else
            it.weight_in = $urandom();

        it.epoch_error  = ($urandom_range(0, 99) < 85) ? $urandom_range(1000, 3000) : $urandom();
        it.last_of_pass = ($urandom_range(0, 11) == 0);
        return it;
    endfunction

    function automatic void push_item(logic [IDX_W-1:0] idx, logic [31:0] g, logic [31:0] w,
                                      logic [31:0] err, bit last, bit known,
                                      logic [31:0] wout, logic [31:0] delta);
        stim_row_t row;
        row.kind                = ROW_ITEM;
        row.reg_id              = REG_GROW_FACTOR;
        row.value               = '0;
        row.it.weight_index     = idx;
        row.it.gradient         = g;
        row.it.weight_in        = w;
        row.it.epoch_error      = err;
        row.it.last_of_pass     = last;
        row.known               = known;
        row.res.weight_out      = wout;
        row.res.weight_delta    = delta;
        directed_rows.push_back(row);
    endfunction

    function automatic void push_cfg(cfg_reg_t r, logic [31:0] v);
        stim_row_t row;
        row        = '{kind: ROW_CFG, reg_id: r, value: v, it: '0, known: 1'b0, res: '0};
        directed_rows.push_back(row);
    endfunction

    // Directed table. Typed results are the ones obvious from the rules: a
    // fresh weight moving by the initial step, saturation at both rails, a
    // zero gradient, and the zero band swallowing a small gradient. The rest
    // (growth, sign flip with and without revert, revert of the most negative
    // change, step collapsing to zero) is left to the predictor.
    function automatic void build_directed();
        // reset settings: initial step 6554
        push_item(10'd0,    32'h0001_0000, 32'h0000_0000, 32'd0,   1'b0, 1'b1,
                  32'd6554, 32'd6554);
        push_item(10'd1,    32'hFFFF_0000, 32'h8000_0000, 32'd0,   1'b0, 1'b1,
                  32'h8000_0000, -32'sd6554);
        push_item(10'd2,    32'h0001_0000, 32'h7FFF_FFFF, 32'd0,   1'b0, 1'b1,
                  32'h7FFF_FFFF, 32'd6554);
        push_item(10'd3,    32'h0000_0000, 32'h1234_5678, 32'd0,   1'b0, 1'b1,
                  32'h1234_5678, 32'd0);
        push_item(10'd0,    32'h0002_0000, 32'd6554,      32'd0,   1'b0, 1'b0, '0, '0);
        push_item(10'd0,    32'hFFFF_0000, 32'h0000_0000, 32'd100, 1'b1, 1'b0, '0, '0);
        push_item(10'd0,    32'hFFFF_0000, 32'h0000_0000, 32'd0,   1'b0, 1'b0, '0, '0);
        push_item(10'd1,    32'h0001_0000, 32'h0000_0000, 32'd50,  1'b0, 1'b0, '0, '0);
        push_item(10'd1023, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
                  32'd6554, 32'd6554);
        push_item(10'd1023, 32'h8000_0000, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
        // steps beyond the signed range
        push_cfg(REG_STEP_INITIAL, 32'hFFFF_FFFF);
        push_cfg(REG_GROW_FACTOR,  32'h0000_FFFF);
        push_cfg(REG_STEP_CEILING, 32'hFFFF_FFFF);
        push_item(10'd4,    32'hFFFF_0000, 32'h0000_0000, 32'd0,   1'b0, 1'b1,
                  32'h8000_0000, 32'h8000_0000);
        push_item(10'd5,    32'h0001_0000, 32'h7FFF_FFFF, 32'd0,   1'b0, 1'b1,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(10'd4,    32'hFFFF_0000, 32'h0000_0000, 32'd0,   1'b0, 1'b0, '0, '0);
        push_item(10'd6,    32'h0000_0000, 32'h0000_0000, 32'd0,   1'b1, 1'b1,
                  32'h0000_0000, 32'h0000_0000);
        push_item(10'd4,    32'h0001_0000, 32'h0000_0000, 32'd5,   1'b0, 1'b0, '0, '0);
        // widest zero band
        push_cfg(REG_ZERO_BAND, 32'hFFFF_FFFF);
        push_item(10'd7,    32'h0000_FFFF, 32'h0000_0001, 32'd0,   1'b0, 1'b1,
                  32'h0000_0001, 32'h0000_0000);
        // shrink to nothing
        push_cfg(REG_SHRINK_FACTOR, 32'd0);
        push_cfg(REG_STEP_FLOOR,    32'd0);
        push_item(10'd5,    32'hFFFF_0000, 32'h0000_0000, 32'd7,   1'b0, 1'b0, '0, '0);
        push_item(10'd5,    32'h0001_0000, 32'h0000_0000, 32'd7,   1'b0, 1'b0, '0, '0);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        setting_t plan [5];
        result_t  none;

        none = '0;
        for (int i = 0; i < WEIGHT_COUNT; i++)
        begin
            seen_mem[i]   = 1'b0;
            kept_mem[i]   = '0;
            change_mem[i] = '0;
            step_mem[i]   = '0;
            last_grad[i]  = '0;
        end
        for (int i = 0; i < HOT_COUNT; i++)
            hot_idx[i] = IDX_W'($urandom_range(0, WEIGHT_COUNT-1));
        build_directed();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; register rows wait for the pipeline to empty
        settings_run++;
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(directed_rows[k].reg_id, directed_rows[k].value);
            end
            else
            begin
                send_item(directed_rows[k].it, directed_rows[k].known, directed_rows[k].res);
                after_item();
            end
        end

        // random phases, each under its own register setting
        plan = '{SET_DEFAULT, SET_TYPICAL, SET_LOW, SET_HIGH, SET_TYPICAL};
        foreach (plan[p])
        begin
            wait_idle();
            apply_setting(plan[p]);
            repeat (PHASE_ITEMS)
            begin
                send_item(random_item(), 1'b0, none);
                after_item();
            end
        end

        wait_idle();
        if (due_results.size() != 0)
        begin
            errors += due_results.size();
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
        end
        $display("Covered %0d weight transactions (%0d results) under %0d register settings,",
                 items_taken, results_seen, settings_run);
        $display("with %0d register writes checked by read-back.", reg_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
